>>> rtl/sfdac_pkg.sv
// ----------------------------------------------------------------------------
// sfdac_pkg
// Shared constants and the floating-point word decoder for the serial DAC.
// ----------------------------------------------------------------------------
package sfdac_pkg;

  // Resampler fixed-point format
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned CNT_W      = 40;
  localparam int unsigned RATE_W     = 32;
  localparam logic [RATE_W-1:0] RATE_RESET = 32'd5319479;
  localparam logic [CNT_W-1:0]  CNT_STEP   = CNT_W'(1) << FRAC_BITS;

  // Serial word layout
  localparam int unsigned SHIFT_W = 14;
  localparam int unsigned LATCH_W = 13;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned MAN_W   = 9;

  // Configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  typedef enum logic [0:0] {
    REG_RATE_DIVIDER = 1'b0
  } reg_idx_t;

  // Decode a 13-bit latch into a signed 16-bit level
  function automatic logic signed [LEVEL_W-1:0] decode_word(input logic [LATCH_W-1:0] w);
    logic [2:0]         ex;
    logic               sgn;
    logic [MAN_W-1:0]   man;
    logic [LEVEL_W-1:0] mask;
    logic [LEVEL_W-1:0] shifted;
    ex      = w[12:10];
    sgn     = w[9];
    man     = w[MAN_W-1:0];
    mask    = sgn ? '0 : '1;
    man     = man ^ mask[MAN_W-1:0];
    shifted = LEVEL_W'(man) << ex;
    if (ex == 3'd0) begin
      decode_word = '0;
    end else begin
      decode_word = (shifted >> 1) ^ mask;
    end
  endfunction

endpackage

>>> rtl/serial_float_dac_with_resampler_core.sv
// ----------------------------------------------------------------------------
// serial_float_dac_with_resampler_core
// Serial floating-point DAC front end with a fixed-point down-counting
// resampler that picks one decoded level per output sample period.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Word
//  in_      input      in_valid / in_stall    serial_clock, serial_data, load_pin
//  out_     output     out_valid / out_stall  dac_level, resampled_value, sample_ready
//  cfg      APB slave  psel/penable/pready    rate_divider at byte address 0
//
//  One word in, one word out: the pin-edge logic, the decoder
//  and the counter update sit between the state registers and the output
//  register, so a word is accepted every cycle the output register is free
//  or being drained in that same cycle.
//  Result appears on the output in the cycle after acceptance.
//  in_stall rises only while a result waits and out_stall is high.
//  Synchronous active-low reset clears the pin, shift, latch, level and valid
//  state; rate and counter load the reset divider; a divider write reloads both.
//
module serial_float_dac_with_resampler_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_serial_clock,
  input  logic                               in_serial_data,
  input  logic                               in_load_pin,
  // result words
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [sfdac_pkg::LEVEL_W-1:0] out_dac_level,
  output logic signed [sfdac_pkg::LEVEL_W-1:0] out_resampled_value,
  output logic                               out_sample_ready,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sfdac_pkg::ADDR_W-1:0]       paddr,
  input  logic [sfdac_pkg::DATA_W-1:0]       pwdata,
  output logic [sfdac_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);

  // State
  logic [sfdac_pkg::RATE_W-1:0]         rate_r;
  logic [sfdac_pkg::SHIFT_W-1:0]        shift_r,   shift_nxt;
  logic                                 sclk_r;
  logic                                 samp_ld_r, samp_ld_nxt;
  logic                                 held_ld_r, held_ld_nxt;
  logic [sfdac_pkg::LATCH_W-1:0]        latch_r,   latch_nxt;
  logic [sfdac_pkg::CNT_W-1:0]          cnt_r,     cnt_nxt;
  logic signed [sfdac_pkg::LEVEL_W-1:0] capt_r,    capt_nxt;

  // Output register
  logic                                 out_valid_r;
  logic signed [sfdac_pkg::LEVEL_W-1:0] out_level_r;
  logic signed [sfdac_pkg::LEVEL_W-1:0] out_resamp_r;
  logic                                 out_ready_r;

  logic                                 accept;
  logic                                 cfg_wr;
  logic                                 cfg_sel_rate;
  logic                                 sclk_rise, sclk_fall;
  logic signed [sfdac_pkg::LEVEL_W-1:0] level_nxt;
  logic [sfdac_pkg::CNT_W-1:0]          cnt_dec, cnt_wrap;
  logic                                 fire;

  // Handshakes
  assign in_stall     = out_valid_r & out_stall;
  assign accept       = in_valid & ~in_stall;
  assign pready       = 1'b1;
  assign cfg_wr       = psel & penable & pwrite;
  assign cfg_sel_rate = (paddr[sfdac_pkg::ADDR_W-1:2] == 1'(sfdac_pkg::REG_RATE_DIVIDER));
  assign prdata       = cfg_sel_rate ? rate_r : '0;

  // Serial pin edges, shift word and load latch
  assign sclk_rise = ~sclk_r & in_serial_clock;
  assign sclk_fall = sclk_r & ~in_serial_clock;

  always_comb begin
    shift_nxt   = shift_r;
    samp_ld_nxt = samp_ld_r;
    held_ld_nxt = held_ld_r;
    latch_nxt   = latch_r;
    if (sclk_rise) begin
      shift_nxt   = {in_serial_data, shift_r[sfdac_pkg::SHIFT_W-1:1]};
      samp_ld_nxt = in_load_pin;
    end
    if (sclk_fall) begin
      held_ld_nxt = samp_ld_nxt;
    end
    if (held_ld_nxt && !samp_ld_nxt) begin
      latch_nxt = shift_nxt[sfdac_pkg::LATCH_W-1:0];
    end
  end

  assign level_nxt = sfdac_pkg::decode_word(latch_nxt);

  // Resample counter: step down, add the divider on zero or below
  assign cnt_dec  = cnt_r - sfdac_pkg::CNT_STEP;
  assign cnt_wrap = cnt_r - sfdac_pkg::CNT_STEP + sfdac_pkg::CNT_W'(rate_r);
  assign fire     = (cnt_dec == '0) | cnt_dec[sfdac_pkg::CNT_W-1];

  always_comb begin
    cnt_nxt  = fire ? cnt_wrap : cnt_dec;
    capt_nxt = fire ? level_nxt : capt_r;
  end

  // Advance state on configuration writes, else on accepted words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= sfdac_pkg::RATE_RESET;
      cnt_r     <= sfdac_pkg::CNT_W'(sfdac_pkg::RATE_RESET);
      shift_r   <= '0;
      sclk_r    <= 1'b0;
      samp_ld_r <= 1'b0;
      held_ld_r <= 1'b0;
      latch_r   <= '0;
      capt_r    <= '0;
    end else if (cfg_wr && cfg_sel_rate) begin
      rate_r <= pwdata;
      cnt_r  <= sfdac_pkg::CNT_W'(pwdata);
    end else if (accept) begin
      shift_r   <= shift_nxt;
      sclk_r    <= in_serial_clock;
      samp_ld_r <= samp_ld_nxt;
      held_ld_r <= held_ld_nxt;
      latch_r   <= latch_nxt;
      cnt_r     <= cnt_nxt;
      capt_r    <= capt_nxt;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_level_r  <= level_nxt;
      out_resamp_r <= capt_nxt;
      out_ready_r  <= fire;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_dac_level       = out_level_r;
  assign out_resampled_value = out_resamp_r;
  assign out_sample_ready    = out_ready_r;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the serial floating-point DAC with resampler.
// Serial frames, broken frames and pin noise are fed as master clock words.
// An in-bench model of the shift register, the latch, the float decoder and
// the resample counter predicts every result word for a field-by-field check.
// The phases vary the rate divider and the sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS    = 55;

  typedef struct packed {
    logic sclk;
    logic sdata;
    logic load;
  } pin_word_t;

  typedef struct packed {
    logic signed [sfdac_pkg::LEVEL_W-1:0] level;
    logic signed [sfdac_pkg::LEVEL_W-1:0] sample;
    logic                                 ready;
  } dac_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_serial_clock = 1'b0;
  logic in_serial_data = 1'b0;
  logic in_load_pin = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [sfdac_pkg::LEVEL_W-1:0] out_dac_level;
  logic signed [sfdac_pkg::LEVEL_W-1:0] out_resampled_value;
  logic out_sample_ready;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [sfdac_pkg::ADDR_W-1:0] paddr = '0;
  logic [sfdac_pkg::DATA_W-1:0] pwdata = '0;
  logic [sfdac_pkg::DATA_W-1:0] prdata;
  logic pready;

  pin_word_t   pin_queue[$];
  dac_result_t expected_results[$];
  int words_in_flight = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int phase_words = 0;

  // DAC model state, matching the reset values of the block
  logic [sfdac_pkg::SHIFT_W-1:0] dac_shift = '0;
  logic                          dac_prev_sclk = 1'b0;
  logic                          dac_load_sampled = 1'b0;
  logic                          dac_load_held = 1'b0;
  logic [sfdac_pkg::LATCH_W-1:0] dac_latch = '0;
  logic [sfdac_pkg::CNT_W-1:0]   resample_count = sfdac_pkg::CNT_W'(sfdac_pkg::RATE_RESET);
  logic [sfdac_pkg::RATE_W-1:0]  rate_divider = sfdac_pkg::RATE_RESET;
  logic [sfdac_pkg::LEVEL_W-1:0] captured_level = '0;

  logic [sfdac_pkg::SHIFT_W-1:0] extreme_frames[8] = '{
    14'h0000, 14'h1C00, 14'h1FFF, 14'h05FF, 14'h1E00, 14'h3FFF, 14'h0400, 14'h1DFF
  };

  serial_float_dac_with_resampler_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_serial_clock     (in_serial_clock),
    .in_serial_data      (in_serial_data),
    .in_load_pin         (in_load_pin),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_dac_level       (out_dac_level),
    .out_resampled_value (out_resampled_value),
    .out_sample_ready    (out_sample_ready),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Turn a 13-bit float latch into its 16-bit level
  function automatic logic [sfdac_pkg::LEVEL_W-1:0] float_level(
      input logic [sfdac_pkg::LATCH_W-1:0] w);
    logic [31:0] mant;
    logic [31:0] mask;
    mask = w[9] ? 32'h0 : 32'hFFFF;
    mant = {23'b0, w[8:0]} ^ (mask & 32'h1FF);
    if (w[12:10] == 3'd0) begin
      return '0;
    end
    return sfdac_pkg::LEVEL_W'(((mant << w[12:10]) >> 1) ^ mask);
  endfunction

  // Advance the DAC model by one master clock word
  function automatic dac_result_t advance_dac(input pin_word_t w);
    dac_result_t r;
    logic [sfdac_pkg::LEVEL_W-1:0] level;
    if (!dac_prev_sclk && w.sclk) begin
      dac_shift = {w.sdata, dac_shift[sfdac_pkg::SHIFT_W-1:1]};
      dac_load_sampled = w.load;
    end
    if (dac_prev_sclk && !w.sclk) begin
      dac_load_held = dac_load_sampled;
    end
    if (dac_load_held && !dac_load_sampled) begin
      dac_latch = dac_shift[sfdac_pkg::LATCH_W-1:0];
    end
    dac_prev_sclk = w.sclk;
    level = float_level(dac_latch);
    r.ready = 1'b0;
    resample_count = resample_count - sfdac_pkg::CNT_STEP;
    if (resample_count == '0 || resample_count[sfdac_pkg::CNT_W-1]) begin
      resample_count = resample_count + sfdac_pkg::CNT_W'(rate_divider);
      captured_level = level;
      r.ready = 1'b1;
    end
    r.level = level;
    r.sample = captured_level;
    return r;
  endfunction

  // Drive pin words; hold the word while stalled
  always @(posedge clk) begin : drive_pins
    pin_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_serial_clock <= 1'b0;
      in_serial_data <= 1'b0;
      in_load_pin <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(advance_dac({in_serial_clock, in_serial_data, in_load_pin}));
      end
      if (!in_valid || !in_stall) begin
        if (pin_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pin_queue.pop_front();
          in_valid <= 1'b1;
          in_serial_clock <= w.sclk;
          in_serial_data <= w.sdata;
          in_load_pin <= w.load;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check result words against the oldest prediction
  always @(posedge clk) begin : check_results
    dac_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: dac_level %0d", out_dac_level);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          words_in_flight--;
          if (out_dac_level !== want.level) begin
            $error("dac_level: expected %0d, got %0d", want.level, out_dac_level);
            mismatch_count++;
          end
          if (out_resampled_value !== want.sample) begin
            $error("resampled_value: expected %0d, got %0d", want.sample, out_resampled_value);
            mismatch_count++;
          end
          if (out_sample_ready !== want.ready) begin
            $error("sample_ready: expected %0d, got %0d", want.ready, out_sample_ready);
            mismatch_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Abort when traffic is pending but nothing moves
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || words_in_flight == 0) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL serial_float_dac_with_resampler_core");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_pins(input logic sclk, input logic sdata, input logic load);
    pin_queue.push_back({sclk, sdata, load});
    words_in_flight++;
    phase_words++;
  endtask

  // Send bits LSB first, each with a low then a high serial clock phase, then rest low
  task automatic push_frame(input logic [sfdac_pkg::SHIFT_W-1:0] bits, input int bit_count,
                            input int load_from, input bit random_load);
    int lo_len;
    int hi_len;
    logic ld;
    for (int i = 0; i < bit_count; i++) begin
      lo_len = ($urandom_range(3) == 0) ? 2 : 1;
      hi_len = ($urandom_range(3) == 0) ? 2 : 1;
      ld = random_load ? 1'($urandom_range(1)) : (i >= load_from && i < bit_count - 1);
      repeat (lo_len) push_pins(1'b0, bits[i], ld);
      repeat (hi_len) push_pins(1'b1, bits[i], ld);
    end
    repeat ($urandom_range(1, 3)) push_pins(1'b0, 1'($urandom_range(1)), 1'b0);
  endtask

  // Mostly well-formed frames, some cut short, some pin noise
  task automatic push_random_words(input int count);
    int pick;
    logic [sfdac_pkg::SHIFT_W-1:0] bits;
    phase_words = 0;
    while (phase_words < count) begin
      pick = $urandom_range(99);
      bits = ($urandom_range(3) == 0) ? extreme_frames[$urandom_range(7)]
                                      : sfdac_pkg::SHIFT_W'($urandom);
      if (pick < 70) begin
        push_frame(bits, sfdac_pkg::SHIFT_W, $urandom_range(sfdac_pkg::SHIFT_W - 2), 1'b0);
      end else if (pick < 85) begin
        push_frame(bits, $urandom_range(1, sfdac_pkg::SHIFT_W - 1), 0, 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          push_pins(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (words_in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the divider over the config port once the block is idle
  task automatic write_divider(input logic [sfdac_pkg::RATE_W-1:0] value);
    wait_drained();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= sfdac_pkg::ADDR_W'(4 * int'(sfdac_pkg::REG_RATE_DIVIDER));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    rate_divider = value;
    resample_count = sfdac_pkg::CNT_W'(value);
  endtask

  task automatic run_phase(input logic [sfdac_pkg::RATE_W-1:0] divider, input int idle_pct,
                           input int stall_pct);
    write_divider(divider);
    @(negedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    push_random_words(PHASE_WORDS);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Every pin combination first, then frames under the reset divider
    @(negedge clk);
    for (int c = 0; c < 8; c++) begin
      push_pins(c[2], c[1], c[0]);
    end
    push_random_words(PHASE_WORDS);

    run_phase(32'h0001_0000, 0, 0);
    run_phase(32'h0000_0001, 64, 0);
    run_phase(32'h0000_0000, 0, 64);
    run_phase(32'hFFFF_FFFF, 19, 19);
    run_phase(sfdac_pkg::RATE_W'($urandom_range(32'h0003_0000, 32'h0010_0000)), 64, 0);
    run_phase(sfdac_pkg::RATE_RESET, 19, 19);

    wait_drained();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS serial_float_dac_with_resampler_core");
    end else begin
      $display("FAIL serial_float_dac_with_resampler_core");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sfdac_pkg.sv
rtl/serial_float_dac_with_resampler_core.sv
dv/testbench.sv
